>>> rtl/core/ovle_pkg.sv
package ovle_pkg;

   // list geometry
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // field widths
   localparam int ACT_W = 4;
   localparam int VAL_W = 32;
   localparam int ST_W  = 2;
   localparam int POS_W = 7;

   // action codes
   localparam logic [ACT_W-1:0] ACT_FRONT_INS  = 4'd0;
   localparam logic [ACT_W-1:0] ACT_BACK_INS   = 4'd1;
   localparam logic [ACT_W-1:0] ACT_BEFORE_KEY = 4'd2;
   localparam logic [ACT_W-1:0] ACT_AFTER_KEY  = 4'd3;
   localparam logic [ACT_W-1:0] ACT_DEL_FRONT  = 4'd4;
   localparam logic [ACT_W-1:0] ACT_DEL_BACK   = 4'd5;
   localparam logic [ACT_W-1:0] ACT_DEL_KEY    = 4'd6;
   localparam logic [ACT_W-1:0] ACT_SEARCH     = 4'd7;
   localparam logic [ACT_W-1:0] ACT_CLEAR      = 4'd8;

   // result status codes
   localparam logic [ST_W-1:0] ST_DONE = 2'd0;
   localparam logic [ST_W-1:0] ST_MISS = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL = 2'd2;

   // where an insert or delete lands
   localparam logic [2:0] POS_FRONT    = 3'd0;
   localparam logic [2:0] POS_TAIL     = 3'd1;
   localparam logic [2:0] POS_HIT      = 3'd2;
   localparam logic [2:0] POS_HIT_NEXT = 3'd3;
   localparam logic [2:0] POS_LAST     = 3'd4;

   typedef struct packed {
      logic            load;
      logic            compare;
      logic            apply;
      logic            ins;
      logic            del;
      logic            clr;
      logic [2:0]      pos_sel;
      logic [ST_W-1:0] status;
      logic            report_pos;
   } dp_cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             found;
      logic             empty;
      logic             full;
   } dp_stat_type;

endpackage

>>> rtl/core/ovle_ctrl.sv
module ovle_ctrl
   import ovle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CMP   = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;
   logic       fire;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign fire       = (state_ff == S_APPLY) && slot_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_tvalid) state_in = S_CMP;
         S_CMP:   state_in = S_APPLY;
         S_APPLY: if (slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (fire) rsp_valid_in = 1'b1;
   end

   // action decode
   always_comb begin
      cmd            = '0;
      cmd.load       = req_tvalid && (state_ff == S_IDLE);
      cmd.compare    = (state_ff == S_CMP);
      cmd.apply      = fire;
      cmd.status     = ST_MISS;
      cmd.pos_sel    = POS_FRONT;
      case (stat.action)
         ACT_FRONT_INS, ACT_BACK_INS: begin
            cmd.pos_sel = (stat.action == ACT_FRONT_INS) ? POS_FRONT : POS_TAIL;
            if (stat.full) begin
               cmd.status = ST_FULL;
            end else begin
               cmd.status = ST_DONE;
               cmd.ins    = fire;
            end
         end
         ACT_BEFORE_KEY, ACT_AFTER_KEY: begin
            cmd.pos_sel = (stat.action == ACT_BEFORE_KEY) ? POS_HIT : POS_HIT_NEXT;
            if (!stat.found) begin
               cmd.status = ST_MISS;
            end else if (stat.full) begin
               cmd.status = ST_FULL;
            end else begin
               cmd.status = ST_DONE;
               cmd.ins    = fire;
            end
         end
         ACT_DEL_FRONT, ACT_DEL_BACK: begin
            cmd.pos_sel = (stat.action == ACT_DEL_FRONT) ? POS_FRONT : POS_LAST;
            if (!stat.empty) begin
               cmd.status = ST_DONE;
               cmd.del    = fire;
            end
         end
         ACT_DEL_KEY: begin
            cmd.pos_sel = POS_HIT;
            if (stat.found) begin
               cmd.status = ST_DONE;
               cmd.del    = fire;
            end
         end
         ACT_SEARCH: begin
            if (stat.found) begin
               cmd.status     = ST_DONE;
               cmd.report_pos = 1'b1;
            end
         end
         ACT_CLEAR: begin
            cmd.status = ST_DONE;
            cmd.clr    = fire;
         end
         default: cmd.status = ST_MISS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/ovle_dp.sv
module ovle_dp
   import ovle_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [ACT_W-1:0] in_action,
   input  logic [VAL_W-1:0] in_key,
   input  logic [VAL_W-1:0] in_value,
   input  dp_cmd_type       cmd,
   output dp_stat_type      stat,
   output logic [ST_W-1:0]  out_status,
   output logic [POS_W-1:0] out_position,
   output logic [POS_W-1:0] out_length
);

   logic [ACT_W-1:0] action_ff;
   logic [VAL_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;
   logic [VAL_W-1:0] entries_ff [CAPACITY];
   logic [VAL_W-1:0] entries_in [CAPACITY];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CAPACITY-1:0] match_ff, match_in;
   logic [CAPACITY-1:0] first_hot;
   logic [IDX_W-1:0] hit_idx;
   logic [CNT_W-1:0] hit_next;
   logic [CNT_W-1:0] pos;
   logic [ST_W-1:0]  status_ff;
   logic [POS_W-1:0] position_ff;
   logic [POS_W-1:0] length_ff;

   // compare every cell against the key, live cells only
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_in[i] = (entries_ff[i] == key_ff) && (CNT_W'(i) < count_ff);
      end
   end

   // first match: isolate lowest set bit, then encode
   assign first_hot = match_ff & (~match_ff + 1'b1);

   always_comb begin
      hit_idx = '0;
      for (int b = 0; b < IDX_W; b++) begin
         for (int j = 0; j < CAPACITY; j++) begin
            if (((j >> b) & 1) == 1) hit_idx[b] = hit_idx[b] | first_hot[j];
         end
      end
   end

   assign hit_next = CNT_W'(hit_idx) + 1'b1;

   always_comb begin
      case (cmd.pos_sel)
         POS_FRONT:    pos = '0;
         POS_TAIL:     pos = count_ff;
         POS_HIT:      pos = CNT_W'(hit_idx);
         POS_HIT_NEXT: pos = hit_next;
         POS_LAST:     pos = count_ff - 1'b1;
         default:      pos = '0;
      endcase
   end

   // each cell keeps its word, takes the new value or a front or back neighbour's
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_in[i] = entries_ff[i];
         if (cmd.ins) begin
            if (CNT_W'(i) == pos) begin
               entries_in[i] = value_ff;
            end else if (CNT_W'(i) > pos) begin
               if (i > 0) entries_in[i] = entries_ff[i-1];
            end
         end else if (cmd.del) begin
            if (CNT_W'(i) >= pos) begin
               if (i < CAPACITY - 1) entries_in[i] = entries_ff[i+1];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clr)      count_in = '0;
      else if (cmd.ins) count_in = count_ff + 1'b1;
      else if (cmd.del) count_in = count_ff - 1'b1;
   end

   assign stat.action = action_ff;
   assign stat.found  = |match_ff;
   assign stat.empty  = (count_ff == '0);
   assign stat.full   = (count_ff >= CNT_W'(CAPACITY));

   assign out_status   = status_ff;
   assign out_position = position_ff;
   assign out_length   = length_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= in_action;
         key_ff    <= in_key;
         value_ff  <= in_value;
      end
      if (cmd.compare) match_ff <= match_in;
      if (cmd.apply) begin
         for (int i = 0; i < CAPACITY; i++) entries_ff[i] <= entries_in[i];
         status_ff   <= cmd.status;
         position_ff <= cmd.report_pos ? POS_W'(hit_next) : '0;
         length_ff   <= POS_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/core/ordered_value_list_engine.sv
// ordered list of up to 64 signed 32-bit words, front first, held in a row of
// cells. each request word names one action: insert at front or back, insert
// before or after the first entry equal to key, delete front, back or first
// entry equal to key, search, or clear. every request gives exactly one
// response word with a status (0 done or found, 1 no match or empty so
// unchanged, 2 full so refused), the 1-based position of a search hit (0 on
// a miss and for every other action) and the list length afterwards.
// undefined action codes leave the list alone and report status 1.
// each request has three steps: capture; compare, in which every cell checks
// its word against the key at once; and apply, in which the first match is
// picked and, on an insert or delete, the cells from that place on shift by
// one place together. the response sits in an output register, so the next
// request is taken while it waits; apply stalls only while it is still untaken.
// the list is empty after reset; no clearing pass is needed.
module ordered_value_list_engine
   import ovle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // action[3:0], key[35:4], value[67:36], zero[71:68]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status[1:0], position[8:2], length[15:9]
);

   dp_cmd_type       cmd;
   dp_stat_type      stat;
   logic [ST_W-1:0]  rsp_status;
   logic [POS_W-1:0] rsp_position;
   logic [POS_W-1:0] rsp_length;

   // sequencing and response handshake
   ovle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // cell row, key compare, first-match encode and result registers
   ovle_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .in_action    (req_tdata[3:0]),
      .in_key       (req_tdata[35:4]),
      .in_value     (req_tdata[67:36]),
      .cmd          (cmd),
      .stat         (stat),
      .out_status   (rsp_status),
      .out_position (rsp_position),
      .out_length   (rsp_length)
   );

   assign rsp_tdata = {rsp_length, rsp_position, rsp_status};

endmodule
